// ===== rtl/core/msgq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the message ring queue.
// Depends on nothing; every other file imports it.
package msgq_pkg;

    localparam int SLOTS         = 16;
    localparam int MAX_MSG_BYTES = 64;

    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int IDX_W    = $clog2(MAX_MSG_BYTES);
    localparam int LEN_W    = $clog2(MAX_MSG_BYTES + 1);
    localparam int MEM_AW   = SLOT_W + IDX_W;
    localparam int MEM_DEPTH = SLOTS * MAX_MSG_BYTES;

    // Field widths fixed by the interface
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int CAP_W      = 7;
    localparam int SLOTS_CFG_W = 5;
    localparam int MAXB_CFG_W = 7;
    localparam int FILL_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSG_BYTES = 1'b1;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Queue depths (powers of two)
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_BLOCK = 2'd1,
        ST_LONG  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_WRITE     = 2'd0,
        CMD_WRITE_RES = 2'd1,
        CMD_RESULT    = 2'd2,
        CMD_STREAM    = 2'd3
    } t_cmd_kind;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_STREAM = 2'd1,
        BK_DRAIN  = 2'd2
    } t_back_state;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [SLOT_W-1:0]  slot;
        logic [IDX_W-1:0]   idx;
        logic [BYTE_W-1:0]  data;
        t_status            status;
        logic [LEN_W-1:0]   len;
        logic [FILL_W-1:0]  fill;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               end_of_run;
        logic [LEN_W-1:0]   message_length;
        logic [FILL_W-1:0]  fill_count;
    } t_result;

endpackage

// ===== rtl/core/message_ring_queue.sv =====
`timescale 1ns / 1ps
// Top level of the message ring queue: front end, command queue, back end.
// Depends on msgq_pkg, msgq_front, msgq_cmd_fifo and msgq_back.
//
// Usage
//   Input side behaves as a queue: drive push with i_op, i_data_byte, i_last and
//   i_capacity; a beat is taken on a clock edge with push high and full low.
//   A push beat carries one message byte (i_last on the final one); a pop beat
//   asks for the oldest message, i_capacity being the most bytes it can take.
//   Result side behaves as a queue too: while empty is low the oldest result
//   sits on the o_ ports; it is taken on an edge with pop high and empty low.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 slots in use, 1 largest message); write only while the block is idle.
// Timing
//   The front end takes one beat per cycle while full is low and settles all
//   bookkeeping at once. A result of a push or a refused pop is registered in
//   the command queue and then in the result queue. A pop occupies the back end
//   for a load, one store read per byte and a drain; its first byte passes the
//   store read register, then one byte per cycle while the receiver keeps up.
// Reset and stalls
//   Reset (synchronous, active low) empties both queues, drops all held
//   messages and restores 16 slots / 64 bytes; the byte store is not cleared.
//   When pop stays low the 4-deep result queue fills, the back end halts, the
//   4-deep command queue fills and full rises until results are taken.
module message_ring_queue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [msgq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [msgq_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic                               i_op,
    input  logic [msgq_pkg::BYTE_W-1:0]        i_data_byte,
    input  logic                               i_last,
    input  logic [msgq_pkg::CAP_W-1:0]         i_capacity,
    output logic                               empty,
    input  logic                               pop,
    output logic [msgq_pkg::STATUS_W-1:0]      o_status,
    output logic [msgq_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                               o_byte_valid,
    output logic                               o_end_of_run,
    output logic [msgq_pkg::LEN_W-1:0]         o_message_length,
    output logic [msgq_pkg::FILL_W-1:0]        o_fill_count
);
    import msgq_pkg::*;

    logic     accept;
    logic     fe_cmd_vld;
    t_cmd     fe_cmd;
    logic     cq_vld;
    t_cmd     cq_cmd;
    logic     bk_deq;
    t_result  bk_res;

    // Take a beat only when the command queue has room
    assign accept = push && !full;

    msgq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_capacity  (i_capacity),
        .o_cmd_vld   (fe_cmd_vld),
        .o_cmd       (fe_cmd)
    );

    // Decouple bookkeeping from the byte store and the streaming sequencer
    msgq_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (fe_cmd_vld),
        .i_cmd   (fe_cmd),
        .i_deq   (bk_deq),
        .o_full  (full),
        .o_vld   (cq_vld),
        .o_cmd   (cq_cmd)
    );

    msgq_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (cq_vld),
        .i_cmd     (cq_cmd),
        .o_cmd_deq (bk_deq),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (bk_res)
    );

    assign o_status         = bk_res.status;
    assign o_out_byte       = bk_res.out_byte;
    assign o_byte_valid     = bk_res.byte_valid;
    assign o_end_of_run     = bk_res.end_of_run;
    assign o_message_length = bk_res.message_length;
    assign o_fill_count     = bk_res.fill_count;

endmodule

// ===== rtl/core/msgq_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, ring bookkeeping and length table.
// Turns each accepted beat into a command for the back end. Uses msgq_pkg.
module msgq_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [msgq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [msgq_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_accept,
    input  logic                               i_op,
    input  logic [msgq_pkg::BYTE_W-1:0]        i_data_byte,
    input  logic                               i_last,
    input  logic [msgq_pkg::CAP_W-1:0]         i_capacity,
    output logic                               o_cmd_vld,
    output msgq_pkg::t_cmd                     o_cmd
);
    import msgq_pkg::*;

    logic [SLOTS_CFG_W-1:0] r_slots_in_use;
    logic [MAXB_CFG_W-1:0]  r_max_bytes;
    logic [SLOT_W-1:0]      r_ws, n_ws;
    logic [CNT_W-1:0]       r_held, n_held;
    logic [LEN_W-1:0]       r_pbc, n_pbc;
    logic                   r_disc, n_disc;
    logic [LEN_W-1:0]       r_len_tab [SLOTS];

    logic [CNT_W-1:0]       eff_slots;
    logic [LEN_W-1:0]       limit;
    logic [CNT_W-1:0]       ws_ext;
    logic [CNT_W-1:0]       ws_inc;
    logic [CNT_W-1:0]       rd_diff;
    logic [SLOT_W-1:0]      rd_slot;
    logic [LEN_W-1:0]       rd_len;
    logic [LEN_W-1:0]       pbc_inc;
    logic                   lt_we;

    always_comb begin
        if (r_slots_in_use == '0) begin
            eff_slots = CNT_W'(1);
        end else if (r_slots_in_use > SLOTS_CFG_W'(SLOTS)) begin
            eff_slots = CNT_W'(SLOTS);
        end else begin
            eff_slots = CNT_W'(r_slots_in_use);
        end
    end

    assign limit   = (r_max_bytes > MAXB_CFG_W'(MAX_MSG_BYTES)) ?
                     LEN_W'(MAX_MSG_BYTES) : LEN_W'(r_max_bytes);
    assign ws_ext  = CNT_W'(r_ws);
    assign ws_inc  = ws_ext + CNT_W'(1);
    assign pbc_inc = r_pbc + LEN_W'(1);

    // Oldest slot: walk back from the write slot by the held count
    assign rd_diff = (ws_ext >= r_held) ? (ws_ext - r_held) : (eff_slots - r_held + ws_ext);
    assign rd_slot = rd_diff[SLOT_W-1:0];
    assign rd_len  = (r_len_tab[rd_slot] > LEN_W'(MAX_MSG_BYTES)) ?
                     LEN_W'(MAX_MSG_BYTES) : r_len_tab[rd_slot];

    always_comb begin
        n_ws      = r_ws;
        n_held    = r_held;
        n_pbc     = r_pbc;
        n_disc    = r_disc;
        lt_we     = 1'b0;
        o_cmd_vld = 1'b0;
        o_cmd     = '0;
        if (i_accept) begin
            if (i_op == OP_PUSH) begin
                if (r_disc) begin
                    if (i_last) begin
                        n_disc = 1'b0;
                    end
                end else if ((r_pbc == '0) && (r_held >= eff_slots)) begin
                    n_pbc        = '0;
                    n_disc       = !i_last;
                    o_cmd_vld    = 1'b1;
                    o_cmd.kind   = CMD_RESULT;
                    o_cmd.status = ST_BLOCK;
                    o_cmd.fill   = FILL_W'(r_held);
                end else if (r_pbc >= limit) begin
                    n_pbc        = '0;
                    n_disc       = !i_last;
                    o_cmd_vld    = 1'b1;
                    o_cmd.kind   = CMD_RESULT;
                    o_cmd.status = ST_LONG;
                    o_cmd.fill   = FILL_W'(r_held);
                end else begin
                    o_cmd_vld    = 1'b1;
                    o_cmd.kind   = CMD_WRITE;
                    o_cmd.slot   = r_ws;
                    o_cmd.idx    = r_pbc[IDX_W-1:0];
                    o_cmd.data   = i_data_byte;
                    o_cmd.status = ST_OK;
                    n_pbc        = pbc_inc;
                    if (i_last) begin
                        // Commit: record length, advance the write slot
                        lt_we      = 1'b1;
                        n_pbc      = '0;
                        n_held     = r_held + CNT_W'(1);
                        n_ws       = (ws_inc >= eff_slots) ? '0 : ws_inc[SLOT_W-1:0];
                        o_cmd.kind = CMD_WRITE_RES;
                        o_cmd.len  = pbc_inc;
                        o_cmd.fill = FILL_W'(n_held);
                    end
                end
            end else begin
                if (r_held == '0) begin
                    o_cmd_vld    = 1'b1;
                    o_cmd.kind   = CMD_RESULT;
                    o_cmd.status = ST_BLOCK;
                end else begin
                    n_held       = r_held - CNT_W'(1);
                    o_cmd_vld    = 1'b1;
                    o_cmd.slot   = rd_slot;
                    o_cmd.len    = rd_len;
                    o_cmd.fill   = FILL_W'(n_held);
                    o_cmd.status = ST_OK;
                    if (rd_len > LEN_W'(i_capacity)) begin
                        o_cmd.kind   = CMD_RESULT;
                        o_cmd.status = ST_LONG;
                    end else if (rd_len == '0) begin
                        o_cmd.kind = CMD_RESULT;
                    end else begin
                        o_cmd.kind = CMD_STREAM;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= SLOTS_CFG_W'(SLOTS);
            r_max_bytes    <= MAXB_CFG_W'(MAX_MSG_BYTES);
            r_ws           <= '0;
            r_held         <= '0;
            r_pbc          <= '0;
            r_disc         <= 1'b0;
        end else begin
            r_ws   <= n_ws;
            r_held <= n_held;
            r_pbc  <= n_pbc;
            r_disc <= n_disc;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SLOTS_IN_USE:  r_slots_in_use <= i_cfg_data[SLOTS_CFG_W-1:0];
                    CFG_MAX_MSG_BYTES: r_max_bytes    <= i_cfg_data[MAXB_CFG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (lt_we) begin
            r_len_tab[r_ws] <= pbc_inc;
        end
    end

endmodule

// ===== rtl/core/msgq_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Uses msgq_pkg for the command type and depth.
module msgq_cmd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_enq,
    input  msgq_pkg::t_cmd   i_cmd,
    input  logic             i_deq,
    output logic             o_full,
    output logic             o_vld,
    output msgq_pkg::t_cmd   o_cmd
);
    import msgq_pkg::*;

    t_cmd                 r_buf [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   r_wptr;
    logic [CMDQ_AW-1:0]   r_rptr;
    logic [CMDQ_AW:0]     r_cnt;
    logic                 do_enq;
    logic                 do_deq;

    assign o_full = (r_cnt == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_cmd  = r_buf[r_rptr];
    assign do_enq = i_enq && !o_full;
    assign do_deq = i_deq && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_enq) begin
                r_wptr <= r_wptr + CMDQ_AW'(1);
            end
            if (do_deq) begin
                r_rptr <= r_rptr + CMDQ_AW'(1);
            end
            case ({do_enq, do_deq})
                2'b10:   r_cnt <= r_cnt + (CMDQ_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (CMDQ_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_enq) begin
            r_buf[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/msgq_back.sv =====
`timescale 1ns / 1ps
// Back end: message byte store, pop streaming sequencer and result queue.
// Uses msgq_pkg for commands, results and the sequencer state type.
module msgq_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_vld,
    input  msgq_pkg::t_cmd        i_cmd,
    output logic                  o_cmd_deq,
    input  logic                  i_pop,
    output logic                  o_empty,
    output msgq_pkg::t_result     o_res
);
    import msgq_pkg::*;

    t_back_state             r_state, n_state;
    logic [BYTE_W-1:0]       r_mem [MEM_DEPTH];
    logic [BYTE_W-1:0]       r_rd_data;
    logic                    r_rd_vld;
    logic                    r_rd_end;
    logic [SLOT_W-1:0]       r_stm_slot;
    logic [LEN_W-1:0]        r_stm_len;
    logic [FILL_W-1:0]       r_stm_fill;
    logic [IDX_W-1:0]        r_idx;

    t_result                 r_out [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]      r_owp;
    logic [OUTQ_AW-1:0]      r_orp;
    logic [OUTQ_AW:0]        r_ocnt;

    logic                    space;
    logic                    last_issue;
    logic                    issue;
    logic                    load;
    logic                    mem_we;
    logic                    direct_res;
    logic [MEM_AW-1:0]       rd_addr;
    logic                    oq_wr;
    logic                    oq_rd;
    t_result                 oq_data;

    // Room for one more beat, counting a read still in flight
    assign space      = ((OUTQ_AW+1)'(r_ocnt) + (OUTQ_AW+1)'(r_rd_vld)) <
                        (OUTQ_AW+1)'(OUTQ_DEPTH);
    assign last_issue = ((LEN_W'(r_idx) + LEN_W'(1)) == r_stm_len);
    assign rd_addr    = {r_stm_slot, r_idx};

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_vld && (i_cmd.kind == CMD_STREAM)) begin
                    n_state = BK_STREAM;
                end
            end
            BK_STREAM: begin
                if (space && last_issue) begin
                    n_state = BK_DRAIN;
                end
            end
            BK_DRAIN: n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_deq  = 1'b0;
        mem_we     = 1'b0;
        direct_res = 1'b0;
        load       = 1'b0;
        issue      = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_vld) begin
                    case (i_cmd.kind)
                        CMD_WRITE: begin
                            o_cmd_deq = 1'b1;
                            mem_we    = 1'b1;
                        end
                        CMD_WRITE_RES: begin
                            o_cmd_deq  = space;
                            mem_we     = space;
                            direct_res = space;
                        end
                        CMD_RESULT: begin
                            o_cmd_deq  = space;
                            direct_res = space;
                        end
                        CMD_STREAM: begin
                            o_cmd_deq = 1'b1;
                            load      = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            BK_STREAM: issue = space;
            default: ;
        endcase
    end

    always_comb begin
        oq_data = '0;
        if (r_rd_vld) begin
            oq_data.status         = ST_OK;
            oq_data.out_byte       = r_rd_data;
            oq_data.byte_valid     = 1'b1;
            oq_data.end_of_run     = r_rd_end;
            oq_data.message_length = r_stm_len;
            oq_data.fill_count     = r_stm_fill;
        end else begin
            oq_data.status         = i_cmd.status;
            oq_data.end_of_run     = 1'b1;
            oq_data.message_length = i_cmd.len;
            oq_data.fill_count     = i_cmd.fill;
        end
    end

    assign oq_wr   = r_rd_vld || direct_res;
    assign oq_rd   = i_pop && (r_ocnt != '0);
    assign o_empty = (r_ocnt == '0);
    assign o_res   = r_out[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_rd_vld <= 1'b0;
            r_idx    <= '0;
            r_owp    <= '0;
            r_orp    <= '0;
            r_ocnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (load) begin
                r_idx <= '0;
            end else if (issue) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (oq_wr) begin
                r_owp <= r_owp + OUTQ_AW'(1);
            end
            if (oq_rd) begin
                r_orp <= r_orp + OUTQ_AW'(1);
            end
            case ({oq_wr, oq_rd})
                2'b10:   r_ocnt <= r_ocnt + (OUTQ_AW+1)'(1);
                2'b01:   r_ocnt <= r_ocnt - (OUTQ_AW+1)'(1);
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_stm_slot <= i_cmd.slot;
            r_stm_len  <= i_cmd.len;
            r_stm_fill <= i_cmd.fill;
        end
        if (issue) begin
            r_rd_end <= last_issue;
        end
        if (oq_wr) begin
            r_out[r_owp] <= oq_data;
        end
    end

    // Byte store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[{i_cmd.slot, i_cmd.idx}] <= i_cmd.data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

endmodule

// ===== rtl/core/msgq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the message ring queue, bound to the top level.
// Depends on msgq_pkg and message_ring_queue.
module msgq_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               empty,
    input  logic                               pop,
    input  logic [msgq_pkg::STATUS_W-1:0]      o_status,
    input  logic [msgq_pkg::BYTE_W-1:0]        o_out_byte,
    input  logic                               o_byte_valid,
    input  logic [msgq_pkg::FILL_W-1:0]        o_fill_count
);
    import msgq_pkg::*;

    // Reset drops every waiting result
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // A data beat always reports success
    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_valid) |-> (o_status == ST_OK))
        else $error("byte beat with non-ok status");

    // Status-only beats carry no byte
    a_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_byte_valid) |-> (o_out_byte == '0))
        else $error("status beat with non-zero byte");

    // Never more messages held than slots exist
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_fill_count <= FILL_W'(SLOTS)))
        else $error("fill count beyond slot count");

    // A waiting beat holds while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind message_ring_queue msgq_checker u_msgq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_status     (o_status),
    .o_out_byte   (o_out_byte),
    .o_byte_valid (o_byte_valid),
    .o_fill_count (o_fill_count)
);

// ===== tb/sv/message_ring_queue_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for message_ring_queue: queued push/pop beats scored against a ring
// predictor kept inside the bench. Depends on msgq_pkg and the message_ring_queue RTL.
module message_ring_queue_tb;
    import msgq_pkg::*;

    localparam int STALL_LIMIT   = 3000;  // cycles with no beat taken on either side
    localparam int SETTLE_CYCLES = 12;    // quiet gap once every result has been taken

    typedef struct {
        logic                op;
        logic [BYTE_W-1:0]   data;
        logic                last;
        logic [CAP_W-1:0]    cap;
    } t_queue_beat;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = CFG_SLOTS_IN_USE;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    push = 1'b0;
    logic                    full;
    logic                    i_op = OP_PUSH;
    logic [BYTE_W-1:0]       i_data_byte = '0;
    logic                    i_last = 1'b0;
    logic [CAP_W-1:0]        i_capacity = '0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic [STATUS_W-1:0]     o_status;
    logic [BYTE_W-1:0]       o_out_byte;
    logic                    o_byte_valid;
    logic                    o_end_of_run;
    logic [LEN_W-1:0]        o_message_length;
    logic [FILL_W-1:0]       o_fill_count;

    message_ring_queue u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_op             (i_op),
        .i_data_byte      (i_data_byte),
        .i_last           (i_last),
        .i_capacity       (i_capacity),
        .empty            (empty),
        .pop              (pop),
        .o_status         (o_status),
        .o_out_byte       (o_out_byte),
        .o_byte_valid     (o_byte_valid),
        .o_end_of_run     (o_end_of_run),
        .o_message_length (o_message_length),
        .o_fill_count     (o_fill_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Ring predictor state: byte store, per-slot lengths, write slot, held count,
    // bytes of the message being pushed, and the drop flag for a refused message.
    logic [BYTE_W-1:0]  ring_bytes [SLOTS*MAX_MSG_BYTES];
    int unsigned        slot_len [SLOTS];
    int unsigned        wr_slot = 0;
    int unsigned        held = 0;
    int unsigned        open_len = 0;
    bit                 dropping = 1'b0;
    int unsigned        cfg_slots = 16;
    int unsigned        cfg_max_bytes = 64;

    t_queue_beat        beat_q[$];      // beats waiting for the driver
    t_result            answer_q[$];    // predicted results, oldest first
    t_result            popped_q[$];    // results taken from the block, not yet scored

    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;
    int unsigned        beats_queued = 0;
    int unsigned        beats_taken = 0;
    int unsigned        results_seen = 0;
    int unsigned        mismatches = 0;
    int unsigned        n_ok = 0;
    int unsigned        n_block = 0;
    int unsigned        n_long = 0;
    int unsigned        reg_writes = 0;
    int unsigned        stall_cycles = 0;

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int unsigned ring_slots();
        if (cfg_slots == 0)
            return 1;
        if (cfg_slots > SLOTS)
            return SLOTS;
        return cfg_slots;
    endfunction

    // Fill count is taken from the held count as it stands after the step.
    task automatic expect_answer(input t_status st, input logic [BYTE_W-1:0] b,
                                 input logic valid, input logic fin, input int unsigned len);
        t_result r;
        r.status         = st;
        r.out_byte       = b;
        r.byte_valid     = valid;
        r.end_of_run     = fin;
        r.message_length = LEN_W'(len);
        r.fill_count     = FILL_W'(held);
        answer_q.push_back(r);
    endtask

    task automatic predict_push(input logic [BYTE_W-1:0] b, input logic last);
        int unsigned nslots;
        int unsigned limit;
        int unsigned slot;
        t_status     st;
        nslots = ring_slots();
        limit  = (cfg_max_bytes > MAX_MSG_BYTES) ? MAX_MSG_BYTES : cfg_max_bytes;
        // Swallow the tail of a refused message; its last byte ends the drop.
        if (dropping) begin
            if (last)
                dropping = 1'b0;
            return;
        end
        if (open_len == 0 && held >= nslots) begin
            st = ST_BLOCK;
        end else if (open_len >= limit) begin
            st = ST_LONG;
        end else begin
            slot = wr_slot % SLOTS;
            ring_bytes[slot*MAX_MSG_BYTES + open_len] = b;
            open_len++;
            if (!last)
                return;
            slot_len[slot] = open_len;
            held++;
            wr_slot++;
            if (wr_slot >= nslots)
                wr_slot = 0;
            expect_answer(ST_OK, '0, 1'b0, 1'b1, open_len);
            open_len = 0;
            return;
        end
        open_len = 0;
        dropping = !last;
        expect_answer(st, '0, 1'b0, 1'b1, 0);
    endtask

    task automatic predict_pop(input int unsigned cap);
        int unsigned nslots;
        int unsigned rd;
        int unsigned len;
        nslots = ring_slots();
        if (held == 0) begin
            expect_answer(ST_BLOCK, '0, 1'b0, 1'b1, 0);
            return;
        end
        // Oldest slot sits held places behind the write slot, around the ring.
        rd = (wr_slot >= held) ? wr_slot - held : nslots - held + wr_slot;
        rd = rd % SLOTS;
        held--;
        len = slot_len[rd];
        if (len > MAX_MSG_BYTES)
            len = MAX_MSG_BYTES;
        if (len > cap) begin
            expect_answer(ST_LONG, '0, 1'b0, 1'b1, len);
        end else if (len == 0) begin
            expect_answer(ST_OK, '0, 1'b0, 1'b1, 0);
        end else begin
            for (int i = 0; i < len; i++)
                expect_answer(ST_OK, ring_bytes[rd*MAX_MSG_BYTES + i], 1'b1,
                              (i + 1 == len), len);
        end
    endtask

    // Driver: hold the beat while full, predict on acceptance, then load the next
    // pending beat unless this cycle is an idle one.
    always @(posedge i_clk) begin : beat_driver
        t_queue_beat nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                beats_taken++;
                if (i_op == OP_PUSH)
                    predict_push(i_data_byte, i_last);
                else
                    predict_pop(i_capacity);
            end
            if (!push || !full) begin
                if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = beat_q.pop_front();
                    i_op        <= nxt.op;
                    i_data_byte <= nxt.data;
                    i_last      <= nxt.last;
                    i_capacity  <= nxt.cap;
                    push        <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: take a result beat whenever pop meets a non-empty queue.
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got.status         = t_status'(o_status);
                got.out_byte       = o_out_byte;
                got.byte_valid     = o_byte_valid;
                got.end_of_run     = o_end_of_run;
                got.message_length = o_message_length;
                got.fill_count     = o_fill_count;
                popped_q.push_back(got);
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Score on the falling edge, once every rising-edge update has settled.
    always @(negedge i_clk) begin : result_checker
        t_result got;
        t_result want;
        while (popped_q.size() != 0) begin
            got = popped_q.pop_front();
            results_seen++;
            if (answer_q.size() == 0) begin
                flag_mismatch($sformatf("result %0d unexpected: status %0d byte %02h",
                                        results_seen, got.status, got.out_byte));
            end else begin
                want = answer_q.pop_front();
                case (want.status)
                    ST_OK:    n_ok++;
                    ST_BLOCK: n_block++;
                    default:  n_long++;
                endcase
                if (got.status !== want.status)
                    flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                            results_seen, got.status, want.status));
                if (got.out_byte !== want.out_byte)
                    flag_mismatch($sformatf("result %0d out_byte %02h, want %02h",
                                            results_seen, got.out_byte, want.out_byte));
                if (got.byte_valid !== want.byte_valid)
                    flag_mismatch($sformatf("result %0d byte_valid %b, want %b",
                                            results_seen, got.byte_valid, want.byte_valid));
                if (got.end_of_run !== want.end_of_run)
                    flag_mismatch($sformatf("result %0d end_of_run %b, want %b",
                                            results_seen, got.end_of_run, want.end_of_run));
                if (got.message_length !== want.message_length)
                    flag_mismatch($sformatf("result %0d message_length %0d, want %0d",
                                            results_seen, got.message_length,
                                            want.message_length));
                if (got.fill_count !== want.fill_count)
                    flag_mismatch($sformatf("result %0d fill_count %0d, want %0d",
                                            results_seen, got.fill_count, want.fill_count));
            end
        end
    end

    // Abort when neither side has moved a beat for too long.
    always @(posedge i_clk) begin : stall_watchdog
        if ((push && !full) || (pop && !empty))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] no beat taken for %0d cycles", $time, STALL_LIMIT);
            $display("message_ring_queue_tb: FAIL");
            $finish;
        end
    end

    task automatic add_beat(input logic op, input logic [BYTE_W-1:0] d, input logic last,
                            input int unsigned cap);
        t_queue_beat b;
        b.op   = op;
        b.data = d;
        b.last = last;
        b.cap  = CAP_W'(cap);
        beat_q.push_back(b);
        beats_queued++;
    endtask

    task automatic add_pop(input int unsigned cap);
        add_beat(OP_POP, $urandom_range(0, 255), $urandom_range(0, 1), cap);
    endtask

    function automatic int unsigned random_capacity();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return MAX_MSG_BYTES;
        if (roll < 90)
            return $urandom_range(0, MAX_MSG_BYTES);
        return $urandom_range(0, 3);
    endfunction

    // Mostly short messages, some up to the limit, a few just past it.
    function automatic int unsigned random_length();
        int unsigned lim;
        int unsigned roll;
        lim  = (cfg_max_bytes > MAX_MSG_BYTES) ? MAX_MSG_BYTES : cfg_max_bytes;
        roll = $urandom_range(99);
        if (lim == 0)
            return $urandom_range(1, 3);
        if (roll < 80)
            return $urandom_range(1, (lim < 8) ? lim : 8);
        if (roll < 95)
            return $urandom_range(1, lim);
        return lim + $urandom_range(1, 2);
    endfunction

    // One well-formed message of random bytes, now and then split by a pop.
    task automatic add_message(input int unsigned len, input int unsigned split_pct);
        for (int i = 0; i < len; i++) begin
            if (i > 0 && $urandom_range(99) < split_pct)
                add_pop(random_capacity());
            add_beat(OP_PUSH, $urandom_range(0, 255), (i + 1 == len),
                     $urandom_range(0, MAX_MSG_BYTES));
        end
    endtask

    task automatic wait_all_answered();
        do
            @(negedge i_clk);
        while (beat_q.size() != 0 || push || answer_q.size() != 0 || popped_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_traffic(input int unsigned n, input int unsigned pop_pct);
        int unsigned stop_at;
        int unsigned roll;
        stop_at = beats_queued + n;
        while (beats_queued < stop_at) begin
            roll = $urandom_range(99);
            if (roll < pop_pct)
                add_pop(random_capacity());
            else if (roll < 92)
                add_message(random_length(), 4);
            else
                add_beat(OP_PUSH, $urandom_range(0, 255), $urandom_range(0, 1),
                         $urandom_range(0, MAX_MSG_BYTES));
            // Occasionally hold the sender until the block has answered everything.
            if ($urandom_range(99) == 0)
                wait_all_answered();
        end
    endtask

    // Bring the ring to a clean point before a register write: close any open
    // message, drain every held message, then cycle single-byte messages until the
    // write slot is back at zero so a smaller ring never reads a stale slot.
    task automatic settle_ring();
        int unsigned n;
        wait_all_answered();
        if (open_len != 0 || dropping) begin
            add_beat(OP_PUSH, $urandom_range(0, 255), 1'b1, 0);
            wait_all_answered();
        end
        n = held;
        repeat (n) add_pop(MAX_MSG_BYTES);
        wait_all_answered();
        if (wr_slot != 0) begin
            n = ring_slots() - wr_slot;
            repeat (n) begin
                add_beat(OP_PUSH, $urandom_range(0, 255), 1'b1, 0);
                add_pop(MAX_MSG_BYTES);
            end
            wait_all_answered();
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SLOTS_IN_USE)
            cfg_slots = value & 32'h1f;
        else
            cfg_max_bytes = value & 32'h7f;
        reg_writes++;
        @(negedge i_clk);
    endtask

    task automatic set_ring(input int unsigned slots, input int unsigned max_bytes);
        settle_ring();
        write_reg(CFG_SLOTS_IN_USE, slots);
        write_reg(CFG_MAX_MSG_BYTES, max_bytes);
    endtask

    initial begin : stimulus
        send_idle_pct = 24;
        recv_idle_pct = 60;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset setting, 16 slots of 64 bytes: empty pop, byte extremes,
        // capacity below, at zero and equal to the length, pop inside a message.
        add_pop(MAX_MSG_BYTES);
        add_beat(OP_PUSH, 8'h00, 1'b1, 0);
        add_beat(OP_PUSH, 8'hff, 1'b0, 0);
        add_beat(OP_PUSH, 8'h80, 1'b0, 0);
        add_beat(OP_PUSH, 8'h01, 1'b1, 0);
        add_pop(0);
        add_pop(2);
        add_beat(OP_PUSH, 8'h55, 1'b0, 0);
        add_beat(OP_PUSH, 8'haa, 1'b1, 0);
        add_beat(OP_PUSH, 8'h5a, 1'b0, 0);
        add_pop(MAX_MSG_BYTES);
        add_beat(OP_PUSH, 8'ha5, 1'b1, 0);
        add_pop(2);
        add_message(4, 0);
        add_pop(MAX_MSG_BYTES);
        add_pop(MAX_MSG_BYTES);

        // One slot, one byte: full refusal with and without a tail to drop,
        // too long mid-message and on its last byte, zero capacity.
        set_ring(1, 1);
        add_beat(OP_PUSH, 8'h11, 1'b1, 0);
        add_beat(OP_PUSH, 8'h22, 1'b1, 0);
        add_beat(OP_PUSH, 8'h33, 1'b0, 0);
        add_beat(OP_PUSH, 8'h44, 1'b0, 0);
        add_beat(OP_PUSH, 8'h55, 1'b1, 0);
        add_pop(MAX_MSG_BYTES);
        add_beat(OP_PUSH, 8'h66, 1'b0, 0);
        add_beat(OP_PUSH, 8'h77, 1'b0, 0);
        add_beat(OP_PUSH, 8'h88, 1'b1, 0);
        add_beat(OP_PUSH, 8'h99, 1'b0, 0);
        add_beat(OP_PUSH, 8'haa, 1'b1, 0);
        add_pop(0);
        add_beat(OP_PUSH, 8'hbb, 1'b1, 0);
        add_pop(0);
        random_traffic(10, 35);

        set_ring(4, 8);
        random_traffic(8, 35);
        wait_all_answered();
        random_traffic(8, 30);

        send_idle_pct = 60;
        recv_idle_pct = 24;
        set_ring(0, 64);            // zero slots behaves as one
        random_traffic(10, 35);
        set_ring(16, 0);            // every message refused as too long
        random_traffic(8, 35);
        set_ring(31, 100);          // both clamp to the block's maximum
        random_traffic(20, 20);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_ring(2, 3);
        random_traffic(12, 35);
        set_ring(16, 64);
        add_message(64, 0);
        add_pop(MAX_MSG_BYTES);
        add_message(64, 0);
        add_pop(MAX_MSG_BYTES - 1);
        add_message(65, 0);
        random_traffic(14, 25);
        settle_ring();

        if (answer_q.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived", answer_q.size()));
        $display("covered %0d input beats and %0d result beats over %0d register writes",
                 beats_taken, results_seen, reg_writes);
        $display("results: %0d ok, %0d full or empty, %0d too long; %0d mismatches",
                 n_ok, n_block, n_long, mismatches);
        if (mismatches == 0)
            $display("message_ring_queue_tb: PASS");
        else
            $display("message_ring_queue_tb: FAIL");
        $finish;
    end

endmodule
